>>> hw/rtl/acm_pkg.sv
`timescale 1ns / 1ps

package acm_pkg;

	localparam int MAX_NODES_DEF = 256;
	localparam int ALPHABET_DEF  = 26;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_BUILD  = 2'd1,
		OP_SCAN   = 2'd2,
		OP_SET    = 2'd3
	} op_t;

endpackage

>>> hw/rtl/aho_corasick_matcher_core.sv
`timescale 1ns / 1ps

// Aho-Corasick dictionary matcher, one result word for every input word.
// Input channel (in_valid/in_ready) carries opcode, symbol, last, start_state.
// Output channel (out_valid/out_ready) carries matched, current_state,
// word_end, status through a single output register.
// Opcodes: insert a pattern letter into the trie, build failure links,
// scan one text letter, load the scan state.
// Per word: insert reads the child entry, then checks and writes it; an
//   ignored or dropped letter goes straight to the result. Set scan state
//   stores the state and reads its mark; scan walks the failure chain
//   first. Build visits every trie node breadth-first, each of its letters,
//   and walks the failure chain for every child.
// All state is in synchronous memories with registered reads; every step
// is one memory read plus its decision, so these walks set the time per word.
// After arst_n is released the block sweeps all MAX_NODES * ALPHABET
// entries of the child table (6656 at the defaults), and the link and
// match tables with it, one entry per cycle; in_ready stays low meanwhile.
// A new input word is taken while the previous result waits in the output
// register; if the receiver stalls, the next result holds until it is free.
module aho_corasick_matcher_core #(
	parameter int MAX_NODES = acm_pkg::MAX_NODES_DEF,
	parameter int ALPHABET  = acm_pkg::ALPHABET_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic [$clog2(ALPHABET)-1:0]         symbol,
	input  logic                                last,
	input  logic [$clog2(MAX_NODES+1)-1:0]      start_state,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                matched,
	output logic [$clog2(MAX_NODES+1)-1:0]      current_state,
	output logic                                word_end,
	output logic                                status
);
	import acm_pkg::*;

	localparam int NODE_W = $clog2(MAX_NODES + 1);
	localparam int SYM_W  = $clog2(ALPHABET);
	localparam int SC_W   = $clog2(ALPHABET + 1);
	localparam int CDEPTH = MAX_NODES * ALPHABET;
	localparam int CA_W   = $clog2(CDEPTH);
	localparam int QA_W   = $clog2(MAX_NODES);

	localparam logic [NODE_W-1:0] ROOT    = NODE_W'(1);
	localparam logic [NODE_W-1:0] NMAX    = NODE_W'(MAX_NODES);
	localparam logic [SC_W-1:0]   ALPHA_C = SC_W'(ALPHABET);

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_INS_RD, ST_INS_CHK,
		ST_B_INIT, ST_B_POP, ST_B_X, ST_B_FX, ST_B_MFX, ST_B_MX,
		ST_B_CH, ST_B_CY, ST_B_FW,
		ST_A_RD, ST_A_CHK, ST_A_FL,
		ST_S_MK, ST_S_MR, ST_RESP
	} state_t;

	// memories
	logic [NODE_W-1:0] child_mem [CDEPTH];
	logic [NODE_W-1:0] fail_mem  [MAX_NODES+1];
	logic              mark_mem  [MAX_NODES+1];
	logic [NODE_W-1:0] queue_mem [MAX_NODES];

	logic [NODE_W-1:0] child_rd_q, fail_rd_q, queue_rd_q;
	logic              mark_rd_q;

	state_t            st_q;
	logic [CA_W-1:0]   clr_q;
	logic [NODE_W-1:0] cursor_q, count_q, scan_q;
	logic              drop_q;
	logic [SYM_W-1:0]  sym_q;
	logic              last_q;
	logic [NODE_W-1:0] p_q, hops_q, adv_res_q;
	logic [SC_W-1:0]   asym_q;
	logic              edge_ok_q, adv_build_q;
	logic [NODE_W-1:0] x_q, fx_q, y_q, head_q, tail_q;
	logic              mx_q;
	logic [SC_W-1:0]   s_q;
	logic              res_matched_q, res_wend_q, res_status_q;
	logic [NODE_W-1:0] res_state_q;
	logic              out_valid_q, matched_q, word_end_q, status_q;
	logic [NODE_W-1:0] current_state_q;

	// memory port controls
	logic [NODE_W-1:0] c_node;
	logic [SC_W-1:0]   c_sym;
	logic [CA_W-1:0]   child_ra, child_wa;
	logic              child_we;
	logic [NODE_W-1:0] child_wd;
	logic [NODE_W-1:0] fail_ra, fail_wa, fail_wd;
	logic              fail_we;
	logic [NODE_W-1:0] mark_ra, mark_wa;
	logic              mark_we, mark_wd;
	logic [QA_W-1:0]   queue_wa;
	logic              queue_we;
	logic [NODE_W-1:0] queue_wd;

	logic              ins_zero, ins_drop;
	logic [NODE_W-1:0] ins_nxt;
	logic              y_ok, clr_small;

	assign ins_zero  = (child_rd_q == '0);
	assign ins_drop  = ins_zero && (count_q == NMAX);
	assign ins_nxt   = ins_zero ? NODE_W'(count_q + ROOT) : child_rd_q;
	assign y_ok      = (child_rd_q != '0) && (child_rd_q <= NMAX);
	assign clr_small = (clr_q <= CA_W'(MAX_NODES));

	always_comb begin
		c_node = p_q;
		c_sym  = asym_q;
		unique case (st_q)
			ST_INS_RD, ST_INS_CHK: begin
				c_node = cursor_q;
				c_sym  = SC_W'(sym_q);
			end
			ST_B_CH: begin
				c_node = x_q;
				c_sym  = s_q;
			end
			default: ;
		endcase
		child_ra = CA_W'(CA_W'(c_node - ROOT) * CA_W'(ALPHABET) + CA_W'(c_sym));

		child_we = 1'b0;
		child_wa = child_ra;
		child_wd = ins_nxt;
		fail_ra  = p_q;
		fail_we  = 1'b0;
		fail_wa  = y_q;
		fail_wd  = adv_res_q;
		mark_ra  = adv_res_q;
		mark_we  = 1'b0;
		mark_wa  = x_q;
		mark_wd  = 1'b1;
		queue_we = 1'b0;
		queue_wa = tail_q[QA_W-1:0];
		queue_wd = child_rd_q;

		unique case (st_q)
			ST_CLR: begin
				child_we = 1'b1;
				child_wa = clr_q;
				child_wd = '0;
				fail_we  = clr_small;
				fail_wa  = clr_q[NODE_W-1:0];
				fail_wd  = '0;
				mark_we  = clr_small;
				mark_wa  = clr_q[NODE_W-1:0];
				mark_wd  = 1'b0;
			end
			ST_INS_CHK: begin
				child_we = ins_zero && !ins_drop;
				mark_we  = last_q && !ins_drop;
				mark_wa  = ins_nxt;
			end
			ST_B_INIT: begin
				queue_we = 1'b1;
				queue_wa = '0;
				queue_wd = ROOT;
			end
			ST_B_X:   fail_ra = queue_rd_q;
			ST_B_FX:  mark_ra = (fail_rd_q <= NMAX) ? fail_rd_q : '0;
			ST_B_MFX: begin
				mark_ra = x_q;
				mark_we = mark_rd_q;
			end
			ST_B_CY: begin
				mark_we  = y_ok && mx_q;
				mark_wa  = child_rd_q;
				queue_we = y_ok && (tail_q < NMAX);
			end
			ST_B_FW:  fail_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (child_we)
			child_mem[child_wa] <= child_wd;
		child_rd_q <= child_mem[child_ra];
	end

	always_ff @(posedge clk) begin
		if (fail_we)
			fail_mem[fail_wa] <= fail_wd;
		fail_rd_q <= fail_mem[fail_ra];
	end

	always_ff @(posedge clk) begin
		if (mark_we)
			mark_mem[mark_wa] <= mark_wd;
		mark_rd_q <= mark_mem[mark_ra];
	end

	always_ff @(posedge clk) begin
		if (queue_we)
			queue_mem[queue_wa] <= queue_wd;
		queue_rd_q <= queue_mem[head_q[QA_W-1:0]];
	end

	assign in_ready      = (st_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign matched       = matched_q;
	assign current_state = current_state_q;
	assign word_end      = word_end_q;
	assign status        = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_q       <= '0;
			cursor_q    <= ROOT;
			count_q     <= ROOT;
			scan_q      <= ROOT;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a new result or free on handshake
			if (st_q == ST_RESP && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (st_q)
				ST_CLR: begin
					clr_q <= CA_W'(clr_q + 1'b1);
					if (clr_q == CA_W'(CDEPTH - 1))
						st_q <= ST_IDLE;
				end

				ST_IDLE: begin
					if (in_valid) begin
						sym_q         <= symbol;
						last_q        <= last;
						res_matched_q <= 1'b0;
						res_status_q  <= 1'b0;
						res_state_q   <= scan_q;
						res_wend_q    <= (op_t'(opcode) == OP_SCAN) && last;
						unique case (op_t'(opcode))
							OP_INSERT: begin
								res_state_q <= cursor_q;
								if (SC_W'(symbol) >= ALPHA_C) begin
									st_q <= ST_RESP;
								end else if (drop_q) begin
									res_status_q <= 1'b1;
									if (last) begin
										cursor_q <= ROOT;
										drop_q   <= 1'b0;
									end
									st_q <= ST_RESP;
								end else begin
									st_q <= ST_INS_RD;
								end
							end
							OP_BUILD: st_q <= ST_B_INIT;
							OP_SCAN: begin
								p_q         <= scan_q;
								asym_q      <= SC_W'(symbol);
								hops_q      <= '0;
								adv_build_q <= 1'b0;
								st_q        <= ST_A_RD;
							end
							OP_SET: begin
								adv_res_q <= (start_state >= ROOT && start_state <= NMAX)
									? start_state : ROOT;
								st_q <= ST_S_MK;
							end
							default: st_q <= ST_RESP;
						endcase
					end
				end

				ST_INS_RD: st_q <= ST_INS_CHK;

				ST_INS_CHK: begin
					if (ins_drop) begin
						res_status_q <= 1'b1;
						res_state_q  <= cursor_q;
						if (last_q)
							cursor_q <= ROOT;
						else
							drop_q <= 1'b1;
					end else begin
						if (ins_zero)
							count_q <= ins_nxt;
						res_state_q <= ins_nxt;
						cursor_q    <= last_q ? ROOT : ins_nxt;
					end
					st_q <= ST_RESP;
				end

				// breadth-first link build
				ST_B_INIT: begin
					head_q <= '0;
					tail_q <= ROOT;
					st_q   <= ST_B_POP;
				end
				ST_B_POP: begin
					if (head_q == tail_q) begin
						st_q <= ST_RESP;
					end else begin
						head_q <= NODE_W'(head_q + 1'b1);
						st_q   <= ST_B_X;
					end
				end
				ST_B_X: begin
					x_q  <= queue_rd_q;
					st_q <= ST_B_FX;
				end
				ST_B_FX: begin
					fx_q <= fail_rd_q;
					st_q <= ST_B_MFX;
				end
				ST_B_MFX: begin
					s_q <= '0;
					if (mark_rd_q) begin
						mx_q <= 1'b1;
						st_q <= ST_B_CH;
					end else begin
						st_q <= ST_B_MX;
					end
				end
				ST_B_MX: begin
					mx_q <= mark_rd_q;
					st_q <= ST_B_CH;
				end
				ST_B_CH: st_q <= (s_q == ALPHA_C) ? ST_B_POP : ST_B_CY;
				ST_B_CY: begin
					if (y_ok) begin
						if (tail_q < NMAX)
							tail_q <= NODE_W'(tail_q + 1'b1);
						y_q         <= child_rd_q;
						p_q         <= fx_q;
						asym_q      <= s_q;
						hops_q      <= '0;
						adv_build_q <= 1'b1;
						st_q        <= ST_A_RD;
					end else begin
						s_q  <= SC_W'(s_q + 1'b1);
						st_q <= ST_B_CH;
					end
				end
				ST_B_FW: begin
					s_q  <= SC_W'(s_q + 1'b1);
					st_q <= ST_B_CH;
				end

				// goto with failure fallback, shared by scan and build
				ST_A_RD: begin
					if (p_q == '0) begin
						adv_res_q <= ROOT;
						st_q      <= adv_build_q ? ST_B_FW : ST_S_MK;
					end else begin
						edge_ok_q <= (p_q <= NMAX) && (asym_q < ALPHA_C);
						st_q      <= ST_A_CHK;
					end
				end
				ST_A_CHK: begin
					if (edge_ok_q && child_rd_q != '0) begin
						adv_res_q <= child_rd_q;
						st_q      <= adv_build_q ? ST_B_FW : ST_S_MK;
					end else if (hops_q == NMAX) begin
						adv_res_q <= ROOT;
						st_q      <= adv_build_q ? ST_B_FW : ST_S_MK;
					end else if (p_q > NMAX) begin
						p_q    <= '0;
						hops_q <= NODE_W'(hops_q + 1'b1);
						st_q   <= ST_A_RD;
					end else begin
						st_q <= ST_A_FL;
					end
				end
				ST_A_FL: begin
					p_q    <= fail_rd_q;
					hops_q <= NODE_W'(hops_q + 1'b1);
					st_q   <= ST_A_RD;
				end

				// scan state update and match lookup
				ST_S_MK: begin
					scan_q <= adv_res_q;
					st_q   <= ST_S_MR;
				end
				ST_S_MR: begin
					res_matched_q <= mark_rd_q;
					res_state_q   <= scan_q;
					st_q          <= ST_RESP;
				end

				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						matched_q       <= res_matched_q;
						current_state_q <= res_state_q;
						word_end_q      <= res_wend_q;
						status_q        <= res_status_q;
						st_q            <= ST_IDLE;
					end
				end

				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> tb/aho_corasick_matcher_core_test.sv
`timescale 1ns / 1ps

module aho_corasick_matcher_core_test;
	import acm_pkg::*;

	localparam int NODES = MAX_NODES_DEF;
	localparam int LETTERS = ALPHABET_DEF;
	localparam int IDLE_LIMIT = 200000;

	// one expected result word
	typedef struct packed {
		logic       matched;
		logic [8:0] state;
		logic       word_end;
		logic       status;
	} match_word_t;

	// Trie model plus the queue of expected result words.
	class match_scoreboard;
		int unsigned goto_tab[NODES * LETTERS];
		int unsigned fail[NODES + 1];
		bit          mark[NODES + 1];
		int unsigned count, cursor, scan;
		bit          dropping;
		match_word_t pending[$];
		int          errors;

		function void clear();
			foreach (goto_tab[i]) goto_tab[i] = 0;
			foreach (fail[i]) fail[i] = 0;
			foreach (mark[i]) mark[i] = 0;
			count = 1;
			cursor = 1;
			scan = 1;
			dropping = 0;
			errors = 0;
		endfunction

		function int unsigned edge_of(int unsigned n, int unsigned s);
			if (n < 1 || n > NODES || s >= LETTERS)
				return 0;
			return goto_tab[(n - 1) * LETTERS + s];
		endfunction

		function int unsigned fail_of(int unsigned n);
			return n <= NODES ? fail[n] : 0;
		endfunction

		function bit mark_of(int unsigned n);
			return n <= NODES ? mark[n] : 0;
		endfunction

		// goto with failure fallback, bounded chain walk
		function int unsigned step_state(int unsigned p, int unsigned s);
			int unsigned hops;
			hops = 0;
			while (p != 0 && edge_of(p, s) == 0 && hops < NODES) begin
				p = fail_of(p);
				hops++;
			end
			if (p != 0 && edge_of(p, s) != 0)
				return edge_of(p, s);
			return 1;
		endfunction

		function void build_links();
			int unsigned order[NODES];
			int unsigned head, tail, x, y;
			head = 0;
			tail = 1;
			order[0] = 1;
			while (head < tail) begin
				x = order[head];
				head++;
				if (mark_of(fail_of(x)))
					mark[x] = 1;
				for (int s = 0; s < LETTERS; s++) begin
					y = edge_of(x, s);
					if (y == 0 || y > NODES)
						continue;
					if (mark[x])
						mark[y] = 1;
					if (tail < NODES) begin
						order[tail] = y;
						tail++;
					end
					fail[y] = step_state(fail_of(x), s);
				end
			end
		endfunction

		function void note_word(op_t op, int unsigned sym, bit lst, int unsigned start);
			match_word_t r;
			int unsigned idx, nxt;
			r = '0;
			r.state = scan;
			case (op)
			OP_INSERT: begin
				r.state = cursor;
				if (sym < LETTERS) begin
					if (!dropping) begin
						idx = (cursor - 1) * LETTERS + sym;
						nxt = goto_tab[idx];
						if (nxt == 0) begin
							if (count < NODES) begin
								count++;
								nxt = count;
								goto_tab[idx] = nxt;
							end else
								dropping = 1;
						end
						if (!dropping)
							cursor = nxt;
					end
					r.status = dropping;
					r.state = cursor;
					if (lst) begin
						if (!dropping)
							mark[cursor] = 1;
						cursor = 1;
						dropping = 0;
					end
				end
			end
			OP_BUILD: begin
				build_links();
				r.state = scan;
			end
			OP_SCAN: begin
				scan = step_state(scan, sym);
				r.state = scan;
				r.matched = mark_of(scan);
				r.word_end = lst;
			end
			default: begin
				scan = (start >= 1 && start <= NODES) ? start : 1;
				r.state = scan;
				r.matched = mark_of(scan);
			end
			endcase
			pending.push_back(r);
		endfunction

		function void check_word(match_word_t got);
			match_word_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %p", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic       clk, arst_n;
	logic       in_valid, in_ready, out_valid, out_ready;
	logic [1:0] opcode;
	logic [4:0] symbol;
	logic       last;
	logic [8:0] start_state;
	logic       matched, word_end, status;
	logic [8:0] current_state;

	match_scoreboard board;
	bit  calm;       // final stretch: no idling on either side
	bit  hold_out;   // long receiver stall request
	int  idle_cycles;

	aho_corasick_matcher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .symbol(symbol), .last(last), .start_state(start_state),
		.out_valid(out_valid), .out_ready(out_ready),
		.matched(matched), .current_state(current_state),
		.word_end(word_end), .status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Offer one word; hold it until the handshake, then optionally idle.
	task automatic send_word(op_t op, int unsigned sym, bit lst, int unsigned start);
		int gap;
		opcode <= op;
		symbol <= sym[4:0];
		last <= lst;
		start_state <= start[8:0];
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_word(op, sym, lst, start);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic finish_input();
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// insert a whole pattern of random letters 0 to span
	task automatic add_pattern(int len, int span);
		for (int i = 0; i < len; i++)
			send_word(OP_INSERT, $urandom_range(0, span), i == len - 1, 0);
	endtask

	// Receiver: random stalls, or a long hold when asked.
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				hold_out = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				gap = $urandom_range(1, 14);
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
		end
	end

	// Sample accepted results and watch for a stalled block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_word({matched, current_state, word_end, status});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int kind;
		board = new();
		board.clear();
		calm = 0;
		hold_out = 0;
		idle_cycles = 0;
		arst_n = 0;
		in_valid = 0;
		opcode = OP_INSERT;
		symbol = 0;
		last = 0;
		start_state = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: scan an empty trie, letter extremes, bad letters and states.
		send_word(OP_SCAN, 0, 1, 0);
		send_word(OP_SET, 0, 0, 0);
		send_word(OP_SET, 0, 0, 511);
		send_word(OP_SET, 0, 0, 256);
		send_word(OP_INSERT, 31, 1, 0);    // bad letter ignored
		send_word(OP_INSERT, 0, 0, 0);     // "az"
		send_word(OP_INSERT, 25, 1, 0);
		send_word(OP_INSERT, 25, 1, 0);    // "z"
		send_word(OP_INSERT, 0, 1, 0);     // "a"
		send_word(OP_SCAN, 0, 0, 0);       // scan before any build
		send_word(OP_BUILD, 31, 1, 511);
		send_word(OP_SCAN, 0, 0, 0);
		send_word(OP_SCAN, 25, 1, 0);
		send_word(OP_SCAN, 25, 0, 0);
		send_word(OP_SCAN, 30, 1, 0);      // bad letter falls to root
		send_word(OP_SET, 0, 0, 3);
		send_word(OP_SET, 0, 0, 200);      // node past node count
		send_word(OP_SCAN, 4, 0, 0);
		send_word(OP_INSERT, 1, 0, 0);     // new nodes after a build
		send_word(OP_INSERT, 2, 1, 0);
		send_word(OP_SCAN, 1, 0, 0);
		drain();

		// Receiver holds off while words keep coming.
		hold_out = 1;
		for (int i = 0; i < 30; i++)
			send_word(OP_SCAN, $urandom_range(0, 3), $urandom_range(0, 1), 0);
		drain();

		// Random: mostly patterns over few letters, then build, then text.
		for (int round = 0; round < 10; round++) begin
			for (int p = 0; p < 6; p++)
				add_pattern($urandom_range(1, 6), $urandom_range(1, 4));
			send_word(OP_BUILD, $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 511));
			for (int i = 0; i < 70; i++) begin
				kind = $urandom_range(0, 19);
				if (kind == 0)
					send_word(OP_SET, 0, 0, $urandom_range(0, 511));
				else if (kind == 1)
					send_word(OP_SCAN, $urandom_range(0, 31), $urandom_range(0, 1), 0);
				else
					send_word(OP_SCAN, $urandom_range(0, 4), $urandom_range(0, 1), 0);
			end
			if (round == 4)
				drain();   // sender pauses until all results are back
		end

		// Fill the node store to force dropped inserts, then no idling.
		for (int p = 0; p < 60; p++)
			add_pattern($urandom_range(3, 8), 25);
		calm = 1;
		send_word(OP_BUILD, 0, 0, 0);
		for (int i = 0; i < 120; i++)
			send_word(OP_SCAN, $urandom_range(0, 25), $urandom_range(0, 1), 0);
		for (int i = 0; i < 40; i++)
			send_word(OP_SET, $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 511));
		finish_input();
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
